// ----- hdl/ptdg_pkg.sv -----
// ----------------------------------------------------------------------------
// ptdg_pkg - shared types and constants of the prime trial division generator
// Sequencer states, register map and fixed constants of the sequence.
// ----------------------------------------------------------------------------
`default_nettype none

package ptdg_pkg;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_FETCH,
    S_DIV,
    S_DONE
  } state_t;

  // Register map: register index, taken from paddr[2]
  localparam logic REG_PRIME_COUNT = 1'b0;

  localparam int FIRST_PRIME = 2;
  localparam int FIRST_ODD   = 3;
  localparam int CAND_STEP   = 2;

  localparam int            COUNT_BITS  = 8;
  localparam logic [7:0]    COUNT_RESET = 8'd100;
  localparam int            APB_DATA_W  = 32;
  localparam int            APB_ADDR_W  = 3;

endpackage : ptdg_pkg

`default_nettype wire

// ----- hdl/prime_trial_division_generator.sv -----
// ----------------------------------------------------------------------------
// prime_trial_division_generator - next prime per request, by trial division
// Each transfer on the input channel returns one result transfer holding the
// next prime of the ascending sequence, its index and last/exhausted flags.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, in_restart): one transfer requests the
//   next prime. in_restart = 1 clears the found primes and returns 2 again.
//   Result channel (out_valid/out_ready): one transfer per request carrying
//   out_prime_value, out_prime_index, out_last and out_exhausted.
//   APB port: register 0 (address 0) is prime_count, the length of the
//   sequence, clipped to MAX_PRIMES. Write it only while the block is idle.
// Timing:
//   One request at a time; in_ready is high only in the idle state. With the
//   result register free, a request that needs no search (first prime,
//   exhausted) passes through S_DONE into the output register and in_ready
//   returns at the same edge; no new request is taken before that. A search
//   adds, for each candidate and each stored prime tried, a table read (S_FETCH)
//   and a bit-serial division in the shared remainder unit (S_DIV). Trial
//   stops at the first stored prime that divides the candidate or whose
//   quotient falls below it, or at the last stored prime, so at most about
//   sqrt(p)/ln(sqrt(p)) divisions per candidate.
// Reset: rst_n (synchronous) clears the count, sets candidate to 3 and
//   prime_count to 100. The prime table is not cleared.
// Stall: a finished result waits in the output register; the next request is
//   accepted meanwhile and its result holds until the register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module prime_trial_division_generator #(
  parameter int MAX_PRIMES = 128,
  parameter int VALUE_BITS = 10
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  // request channel
  input  wire                                  in_valid,
  output logic                                 in_ready,
  input  wire                                  in_restart,
  // result channel
  output logic                                 out_valid,
  input  wire                                  out_ready,
  output logic [VALUE_BITS-1:0]                out_prime_value,
  output logic [$clog2(MAX_PRIMES)-1:0]        out_prime_index,
  output logic                                 out_last,
  output logic                                 out_exhausted,
  // configuration port
  input  wire                                  psel,
  input  wire                                  penable,
  input  wire                                  pwrite,
  input  wire  [ptdg_pkg::APB_ADDR_W-1:0]      paddr,
  input  wire  [ptdg_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [ptdg_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                 pready
);

  import ptdg_pkg::*;

  localparam int IW  = $clog2(MAX_PRIMES);        // table index
  localparam int FCW = $clog2(MAX_PRIMES + 1);    // found count
  localparam int W   = VALUE_BITS + 1;            // candidate, may pass the value range
  localparam int CW  = (FCW > COUNT_BITS) ? FCW : COUNT_BITS;
  localparam int BW  = $clog2(W);                 // division step counter

  localparam logic [W-1:0]  VALUE_MAX = {1'b0, {VALUE_BITS{1'b1}}};
  localparam logic [CW-1:0] DEPTH_CW  = CW'(MAX_PRIMES);

  // --------------------------------------------------------------------------
  // Configuration register
  // --------------------------------------------------------------------------
  logic [COUNT_BITS-1:0] prime_count_r;
  logic                  cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_PRIME_COUNT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prime_count_r <= COUNT_RESET;
    end else if (cfg_wr) begin
      prime_count_r <= pwdata[COUNT_BITS-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_PRIME_COUNT) begin
      prdata = APB_DATA_W'(prime_count_r);
    end
  end

  // Clip the count to the table depth
  logic [CW-1:0] limit;
  always_comb begin
    limit = CW'(prime_count_r);
    if (limit > DEPTH_CW) begin
      limit = DEPTH_CW;
    end
  end

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  state_t                state_r, state_nxt;
  logic [FCW-1:0]        found_r, found_nxt;
  logic [W-1:0]          cand_r, cand_nxt;
  logic [IW-1:0]         idx_r, idx_nxt;
  logic [W-1:0]          dvd_r, dvd_nxt;
  logic [W-1:0]          rem_r, rem_nxt;
  logic [W-1:0]          quo_r, quo_nxt;
  logic [BW-1:0]         bit_r, bit_nxt;

  // staged result
  logic [VALUE_BITS-1:0] res_value_r, res_value_nxt;
  logic [IW-1:0]         res_index_r, res_index_nxt;
  logic                  res_last_r, res_last_nxt;
  logic                  res_exh_r, res_exh_nxt;

  // output register
  logic                  out_valid_r, out_valid_nxt;
  logic [VALUE_BITS-1:0] out_value_r, out_value_nxt;
  logic [IW-1:0]         out_index_r, out_index_nxt;
  logic                  out_last_r, out_last_nxt;
  logic                  out_exh_r, out_exh_nxt;

  // prime table
  logic [VALUE_BITS-1:0] prime_mem [MAX_PRIMES];
  logic [VALUE_BITS-1:0] rd_data_r;
  logic                  wr_en;
  logic [IW-1:0]         wr_addr;
  logic [VALUE_BITS-1:0] wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      prime_mem[wr_addr] <= wr_data;
    end
    rd_data_r <= prime_mem[idx_r];
  end

  // --------------------------------------------------------------------------
  // Shared remainder unit: one restoring step per cycle, MSB first
  // --------------------------------------------------------------------------
  logic [W-1:0] divisor;
  logic [W-1:0] shifted;
  logic         step_ge;
  logic [W-1:0] step_rem;
  logic [W-1:0] step_quo;

  assign divisor  = {1'b0, rd_data_r};
  assign shifted  = {rem_r[VALUE_BITS-1:0], dvd_r[W-1]};
  assign step_ge  = (shifted >= divisor);
  assign step_rem = step_ge ? (shifted - divisor) : shifted;
  assign step_quo = {quo_r[W-2:0], step_ge};

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  logic [FCW-1:0] fc_eff;
  logic [W-1:0]   cand_eff;
  logic [W-1:0]   cand_plus;

  assign in_ready  = (state_r == S_IDLE);
  assign cand_plus = cand_r + W'(CAND_STEP);

  always_comb begin
    state_nxt     = state_r;
    found_nxt     = found_r;
    cand_nxt      = cand_r;
    idx_nxt       = idx_r;
    dvd_nxt       = dvd_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    bit_nxt       = bit_r;
    res_value_nxt = res_value_r;
    res_index_nxt = res_index_r;
    res_last_nxt  = res_last_r;
    res_exh_nxt   = res_exh_r;
    wr_en         = 1'b0;
    wr_addr       = found_r[IW-1:0];
    wr_data       = cand_r[VALUE_BITS-1:0];
    fc_eff        = in_restart ? '0 : found_r;
    cand_eff      = (in_restart ? W'(FIRST_ODD) : cand_r) | W'(1);

    // drop the held result once it is taken
    out_valid_nxt = out_valid_r && !out_ready;
    out_value_nxt = out_value_r;
    out_index_nxt = out_index_r;
    out_last_nxt  = out_last_r;
    out_exh_nxt   = out_exh_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          found_nxt     = fc_eff;
          cand_nxt      = cand_eff;
          res_value_nxt = '0;
          res_index_nxt = '0;
          res_last_nxt  = 1'b0;
          res_exh_nxt   = 1'b1;
          if (CW'(fc_eff) >= limit) begin
            state_nxt = S_DONE;
          end else if (fc_eff == '0) begin
            // first prime needs no search
            wr_en         = 1'b1;
            wr_addr       = '0;
            wr_data       = VALUE_BITS'(FIRST_PRIME);
            found_nxt     = FCW'(1);
            res_value_nxt = VALUE_BITS'(FIRST_PRIME);
            res_last_nxt  = (limit == CW'(1));
            res_exh_nxt   = 1'b0;
            state_nxt     = S_DONE;
          end else if (cand_eff > VALUE_MAX) begin
            // every prime in range is stored: hold the candidate past the
            // range so each request stays exhausted until a restart
            state_nxt = S_DONE;
          end else begin
            idx_nxt   = '0;
            dvd_nxt   = cand_eff;
            rem_nxt   = '0;
            quo_nxt   = '0;
            bit_nxt   = '0;
            state_nxt = S_FETCH;
          end
        end
      end

      S_FETCH: begin
        // table read of entry idx_r lands in rd_data_r
        state_nxt = S_DIV;
      end

      S_DIV: begin
        dvd_nxt = dvd_r << 1;
        rem_nxt = step_rem;
        quo_nxt = step_quo;
        bit_nxt = bit_r + BW'(1);
        if (bit_r == BW'(W - 1)) begin
          rem_nxt = '0;
          quo_nxt = '0;
          bit_nxt = '0;
          if (step_rem == '0) begin
            // composite: advance to the next odd candidate
            if (cand_plus > VALUE_MAX) begin
              // range used up; the candidate stays past it
              cand_nxt      = cand_plus;
              res_value_nxt = '0;
              res_index_nxt = '0;
              res_last_nxt  = 1'b0;
              res_exh_nxt   = 1'b1;
              state_nxt     = S_DONE;
            end else begin
              cand_nxt  = cand_plus;
              idx_nxt   = '0;
              dvd_nxt   = cand_plus;
              state_nxt = S_FETCH;
            end
          end else if ((step_quo < divisor) ||
                       (FCW'(idx_r) + FCW'(1) == found_r)) begin
            // divisor beyond the square root, or table exhausted: prime
            wr_en         = 1'b1;
            found_nxt     = found_r + FCW'(1);
            cand_nxt      = cand_plus;
            res_value_nxt = cand_r[VALUE_BITS-1:0];
            res_index_nxt = found_r[IW-1:0];
            res_last_nxt  = (CW'(found_r) + CW'(1) == limit);
            res_exh_nxt   = 1'b0;
            state_nxt     = S_DONE;
          end else begin
            idx_nxt   = idx_r + IW'(1);
            dvd_nxt   = cand_r;
            state_nxt = S_FETCH;
          end
        end
      end

      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = res_value_r;
          out_index_nxt = res_index_r;
          out_last_nxt  = res_last_r;
          out_exh_nxt   = res_exh_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      found_r     <= '0;
      cand_r      <= W'(FIRST_ODD);
      idx_r       <= '0;
      bit_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      found_r     <= found_nxt;
      cand_r      <= cand_nxt;
      idx_r       <= idx_nxt;
      bit_r       <= bit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r       <= dvd_nxt;
    rem_r       <= rem_nxt;
    quo_r       <= quo_nxt;
    res_value_r <= res_value_nxt;
    res_index_r <= res_index_nxt;
    res_last_r  <= res_last_nxt;
    res_exh_r   <= res_exh_nxt;
    out_value_r <= out_value_nxt;
    out_index_r <= out_index_nxt;
    out_last_r  <= out_last_nxt;
    out_exh_r   <= out_exh_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_prime_value = out_value_r;
  assign out_prime_index = out_index_r;
  assign out_last        = out_last_r;
  assign out_exhausted   = out_exh_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while another is in progress");

  a_found_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (CW'(found_r) <= DEPTH_CW))
    else $error("found count above table depth");

  a_exh_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_exhausted) |->
      (out_prime_value == '0 && out_prime_index == '0 && !out_last))
    else $error("exhausted result carries a prime");

  a_prime_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_exhausted) |-> (out_prime_value != '0))
    else $error("zero prime reported");

  a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (rd_data_r != '0))
    else $error("trial division by zero");

endmodule : prime_trial_division_generator

`default_nettype wire

// ----- sim/prime_trial_division_generator_test.sv -----
// ----------------------------------------------------------------------------
// prime_trial_division_generator_test - self-checking bench for the generator
// Requests primes over the valid/ready channel under random gaps and stalls,
// predicts each result with a local trial-division sequence and compares every
// result transfer field by field. Covers reset, zero/saturated counts, count
// changes mid-sequence, restarts, full table depth and output backpressure.
// ----------------------------------------------------------------------------
`default_nettype none

module prime_trial_division_generator_test;

  import ptdg_pkg::*;

  localparam int TABLE_DEPTH = 128;
  localparam int VALUE_W     = 10;
  localparam int INDEX_W     = $clog2(TABLE_DEPTH);
  localparam int VALUE_MAX   = (1 << VALUE_W) - 1;
  localparam int REPORT_MAX  = 10;
  localparam int RANDOM_GOAL = 300;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [INDEX_W-1:0] index;
    logic               last;
    logic               exhausted;
  } prime_result_t;

  // --------------------------------------------------------------------------
  // Clock, reset and block ports; every input starts at a known value
  // --------------------------------------------------------------------------
  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_valid   = 1'b0;
  logic                  in_restart = 1'b0;
  logic                  out_ready  = 1'b0;
  logic                  psel       = 1'b0;
  logic                  penable    = 1'b0;
  logic                  pwrite     = 1'b0;
  logic [APB_ADDR_W-1:0] paddr      = '0;
  logic [APB_DATA_W-1:0] pwdata     = '0;

  logic                  in_ready;
  logic                  out_valid;
  logic [VALUE_W-1:0]    out_prime_value;
  logic [INDEX_W-1:0]    out_prime_index;
  logic                  out_last;
  logic                  out_exhausted;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  prime_trial_division_generator #(
    .MAX_PRIMES (TABLE_DEPTH),
    .VALUE_BITS (VALUE_W)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_restart      (in_restart),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_prime_value (out_prime_value),
    .out_prime_index (out_prime_index),
    .out_last        (out_last),
    .out_exhausted   (out_exhausted),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // --------------------------------------------------------------------------
  // Local copy of the sequence state, updated at each accepted request
  // --------------------------------------------------------------------------
  logic [VALUE_W-1:0] found_primes [TABLE_DEPTH];
  int unsigned        primes_found   = 0;
  int unsigned        odd_candidate  = FIRST_ODD;
  logic [7:0]         prime_count_q  = COUNT_RESET;

  prime_result_t      expected_primes [$];
  int unsigned        requests_sent  = 0;
  int unsigned        mismatch_count = 0;

  // Idle control shared by both sides; the receiver also takes a long hold-off
  bit                 gaps_on        = 1'b1;
  int unsigned        result_hold    = 0;

  // Work out the result of one request and advance the local sequence state
  function automatic prime_result_t next_prime(input logic restart);
    prime_result_t r;
    int unsigned   limit;
    int unsigned   cand;
    int unsigned   idx;
    bit            hit;
    bit            divides;
    r    = '0;
    hit  = 1'b0;
    cand = 0;
    if (restart) begin
      primes_found  = 0;
      odd_candidate = FIRST_ODD;
    end
    // Clip the count to the table depth
    limit = (prime_count_q > TABLE_DEPTH) ? TABLE_DEPTH : prime_count_q;
    if (primes_found < limit) begin
      if (primes_found == 0) begin
        cand = FIRST_PRIME;
        hit  = 1'b1;
      end else begin
        cand = odd_candidate | 1;
        while (!hit && cand <= VALUE_MAX) begin
          divides = 1'b0;
          for (int i = 0; i < primes_found; i++) begin
            if (cand % found_primes[i] == 0) divides = 1'b1;
          end
          if (divides) cand += CAND_STEP;
          else hit = 1'b1;
        end
        // No prime left in range: fall back to the first odd candidate
        odd_candidate = hit ? cand + CAND_STEP : FIRST_ODD;
      end
    end
    if (hit) begin
      idx                            = primes_found;
      found_primes[idx % TABLE_DEPTH] = VALUE_W'(cand);
      primes_found                   = idx + 1;
      r.value                        = VALUE_W'(cand);
      r.index                        = INDEX_W'(idx);
      r.last                         = (primes_found == limit);
    end else begin
      r.exhausted = 1'b1;
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Request side: one transfer per call, random gap in front of it
  // --------------------------------------------------------------------------
  task automatic send_request(input logic restart);
    int unsigned gap;
    gap = gaps_on ? $urandom_range(0, 9) : 0;
    // Drop valid only when a gap is due; back-to-back transfers keep it high
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_restart <= restart;
    do @(posedge clk); while (!in_ready);
    expected_primes = {expected_primes, next_prime(restart)};
    requests_sent++;
  endtask

  // Hold the sender until every expected result has come back
  task automatic wait_results_done();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_primes.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Write prime_count through the APB port; only called while the block idles
  task automatic write_prime_count(input logic [7:0] count);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_PRIME_COUNT, 2'b00};
    pwdata  <= APB_DATA_W'(count);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    prime_count_q = count;
  endtask

  // --------------------------------------------------------------------------
  // Result side: random stall per result, plus an optional long hold-off
  // --------------------------------------------------------------------------
  initial begin
    int unsigned stall;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      // A requested hold-off starts after the next result transfer
      if (result_hold > 0) begin
        out_ready <= 1'b0;
        repeat (result_hold) @(posedge clk);
        result_hold = 0;
      end
      stall = gaps_on ? $urandom_range(0, 9) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  task automatic report_mismatch(input string what, input prime_result_t want,
                                 input prime_result_t got);
    mismatch_count++;
    if (mismatch_count <= REPORT_MAX) begin
      $display("MISMATCH %s: expected value=%0d index=%0d last=%0b exhausted=%0b",
               what, want.value, want.index, want.last, want.exhausted);
      $display("         actual   value=%0d index=%0d last=%0b exhausted=%0b",
               got.value, got.index, got.last, got.exhausted);
    end
  endtask

  // Compare every result transfer with the oldest expectation
  always @(posedge clk) begin
    prime_result_t got;
    prime_result_t want;
    if (rst_n && out_valid && out_ready) begin
      got = '{value: out_prime_value, index: out_prime_index,
              last: out_last, exhausted: out_exhausted};
      if (expected_primes.size() == 0) begin
        report_mismatch("result with no request pending", '0, got);
      end else begin
        want = expected_primes.pop_front();
        if (got.value !== want.value) report_mismatch("prime_value", want, got);
        if (got.index !== want.index) report_mismatch("prime_index", want, got);
        if (got.last !== want.last) report_mismatch("last", want, got);
        if (got.exhausted !== want.exhausted) report_mismatch("exhausted", want, got);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Default count after reset; the very first request needs no restart
  task automatic test_after_reset();
    send_request(1'b0);
    send_request(1'b0);
    send_request(1'b0);
    send_request(1'b1);
    wait_results_done();
  endtask

  // A count of zero gives no primes at all
  task automatic test_zero_count();
    write_prime_count(8'd0);
    send_request(1'b0);
    send_request(1'b1);
    wait_results_done();
  endtask

  // Count of one: 2 is flagged last, then exhausted until restart
  task automatic test_single_prime();
    write_prime_count(8'd1);
    send_request(1'b1);
    send_request(1'b0);
    send_request(1'b0);
    send_request(1'b1);
    wait_results_done();
  endtask

  // Lower the count below the primes found, then raise it and continue
  task automatic test_count_changes();
    write_prime_count(8'd5);
    send_request(1'b1);
    repeat (4) send_request(1'b0);
    wait_results_done();
    write_prime_count(8'd3);
    send_request(1'b0);
    wait_results_done();
    write_prime_count(8'd8);
    send_request(1'b0);
    send_request(1'b0);
    send_request(1'b1);
    wait_results_done();
  endtask

  // Count above the table depth saturates; run the whole table and past it
  task automatic test_full_table();
    write_prime_count(8'd255);
    send_request(1'b1);
    repeat (TABLE_DEPTH + 1) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      send_request(1'b0);
    end
    gaps_on = 1'b1;
    wait_results_done();
  endtask

  // Stall the result side for a long stretch while requests keep coming
  task automatic test_backpressure();
    write_prime_count(8'd20);
    gaps_on     = 1'b0;
    result_hold = 300;
    send_request(1'b1);
    repeat (12) send_request(1'b0);
    wait_results_done();
    gaps_on = 1'b1;
  endtask

  // Mostly complete sequences with random counts, some noise and broken runs
  task automatic test_random_sequences();
    int unsigned count;
    int unsigned run_len;
    while (requests_sent < RANDOM_GOAL) begin
      case ($urandom_range(0, 9))
        0:       count = 0;
        1:       count = 1;
        2:       count = TABLE_DEPTH;
        3:       count = $urandom_range(TABLE_DEPTH + 1, 255);
        default: count = $urandom_range(2, 40);
      endcase
      // Keep the old count now and then so a run continues across phases
      if ($urandom_range(0, 3) != 0) write_prime_count(8'(count));
      run_len = (prime_count_q > 40) ? $urandom_range(1, 30)
                                     : prime_count_q + $urandom_range(0, 3);
      gaps_on = ($urandom_range(0, 4) != 0);
      send_request($urandom_range(0, 9) != 0);
      repeat (run_len) send_request($urandom_range(0, 19) == 0);
      wait_results_done();
    end
    gaps_on = 1'b1;
  endtask

  // --------------------------------------------------------------------------
  // Sequence of tests and final verdict
  // --------------------------------------------------------------------------
  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_after_reset();
    test_zero_count();
    test_single_prime();
    test_count_changes();
    test_full_table();
    test_backpressure();
    test_random_sequences();
    wait_results_done();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && expected_primes.size() == 0) begin
      $display("prime_trial_division_generator_test passed");
    end else begin
      $display("prime_trial_division_generator_test failed");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run
  initial begin
    #40_000_000;
    $display("prime_trial_division_generator_test failed");
    $finish;
  end

endmodule : prime_trial_division_generator_test

`default_nettype wire
